// File: hdl/quadtree_tile_locator_assert.svh
// ----------------------------------------------------------------------------
// Quadtree tile locator assertion macros
// Shared property forms for the checker of the tile locator ports.
// ----------------------------------------------------------------------------
`ifndef QUADTREE_TILE_LOCATOR_ASSERT_SVH
`define QUADTREE_TILE_LOCATOR_ASSERT_SVH

// Antecedent implies consequent in the same cycle, checked out of reset.
`define QTL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The expression must never be true out of reset.
`define QTL_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`endif

// File: hdl/qtl_pkg.sv
// ----------------------------------------------------------------------------
// Quadtree tile locator package
// Widths, codes, the control struct and helpers shared by the locator files.
// ----------------------------------------------------------------------------
`default_nettype none

package qtl_pkg;

  localparam int DATA_W             = 32;
  localparam int TILE_W             = 24;
  localparam int LEVEL_W            = 5;
  localparam int ROOT_W             = 5;
  localparam int QUO_W              = 32;
  localparam int PADDR_W            = 5;
  localparam int DEF_MAX_LEVEL      = 20;
  localparam int DEF_MAX_ROOT_TILES = 16;
  // Edges from the accepting edge to the edge that raises the result strobe.
  localparam int LATENCY            = QUO_W + 2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_LEVEL = 2'd2,
    ST_TILE  = 2'd3
  } status_t;

  typedef enum logic {
    OP_LOCATE = 1'b0,
    OP_EDGES  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    REG_MIN_X  = 3'd0,
    REG_MIN_Y  = 3'd1,
    REG_MAX_X  = 3'd2,
    REG_MAX_Y  = 3'd3,
    REG_ROOT_X = 3'd4,
    REG_ROOT_Y = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic    valid;
    op_t     op;
    status_t status;
  } qtl_ctrl_t;

  // A root count of zero counts as one; counts above the limit are clipped.
  function automatic logic [ROOT_W-1:0] root_count(input logic [ROOT_W-1:0] r,
                                                   input logic [ROOT_W-1:0] maxr);
    logic [ROOT_W-1:0] res;
    begin
      if (r == '0) begin
        res = ROOT_W'(1);
      end else if (r > maxr) begin
        res = maxr;
      end else begin
        res = r;
      end
      return res;
    end
  endfunction

endpackage

`default_nettype wire

// File: hdl/qtl_front.sv
// ----------------------------------------------------------------------------
// Quadtree tile locator front end
// Decodes a query, checks it against the rectangle and forms the four
// dividend and divisor pairs in two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module qtl_front #(
  parameter int MAX_LEVEL      = qtl_pkg::DEF_MAX_LEVEL,
  parameter int MAX_ROOT_TILES = qtl_pkg::DEF_MAX_ROOT_TILES,
  parameter int NXW            = $clog2(MAX_ROOT_TILES + 1) + MAX_LEVEL,
  parameter int PW             = qtl_pkg::DATA_W + NXW
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                start,
  input  wire                                in_operation,
  input  wire  [qtl_pkg::LEVEL_W-1:0]        in_level,
  input  wire  signed [qtl_pkg::DATA_W-1:0]  in_pos_x,
  input  wire  signed [qtl_pkg::DATA_W-1:0]  in_pos_y,
  input  wire  [qtl_pkg::TILE_W-1:0]         in_tile_x_in,
  input  wire  [qtl_pkg::TILE_W-1:0]         in_tile_y_in,
  input  wire  signed [qtl_pkg::DATA_W-1:0]  rect_min_x,
  input  wire  signed [qtl_pkg::DATA_W-1:0]  rect_min_y,
  input  wire  signed [qtl_pkg::DATA_W-1:0]  rect_max_x,
  input  wire  signed [qtl_pkg::DATA_W-1:0]  rect_max_y,
  input  wire  [qtl_pkg::ROOT_W-1:0]         root_tiles_x,
  input  wire  [qtl_pkg::ROOT_W-1:0]         root_tiles_y,
  output qtl_pkg::qtl_ctrl_t                 ctrl_o,
  output logic [qtl_pkg::DATA_W-1:0]         min_x_o,
  output logic [qtl_pkg::DATA_W-1:0]         min_y_o,
  output logic [NXW-1:0]                     nx_m1_o,
  output logic [NXW-1:0]                     ny_m1_o,
  output logic [PW-1:0]                      dvd_o [4],
  output logic [qtl_pkg::DATA_W-1:0]         dvs_o [4]
);
  import qtl_pkg::*;

  localparam int CW = (NXW > TILE_W) ? NXW : TILE_W;

  logic signed [DATA_W:0] dx_c, dy_c, offx_c, offy_c;
  logic                   w_ok_c, h_ok_c, inside_c, beyond_c;
  logic [NXW-1:0]         nx_c, ny_c;
  qtl_ctrl_t              s1_ctrl_nxt;

  qtl_ctrl_t          s1_ctrl_r;
  logic [DATA_W-1:0]  s1_offx_r, s1_offy_r, s1_w_r, s1_h_r, s1_minx_r, s1_miny_r;
  logic [NXW-1:0]     s1_nx_r, s1_ny_r, s1_tx_r, s1_ty_r;

  logic [DATA_W-1:0]  a0_c, a1_c;
  logic [NXW-1:0]     b0_c, b1_c, tx1_c, ty1_c;

  always_comb begin
    dx_c     = {rect_max_x[DATA_W-1], rect_max_x} - {rect_min_x[DATA_W-1], rect_min_x};
    dy_c     = {rect_max_y[DATA_W-1], rect_max_y} - {rect_min_y[DATA_W-1], rect_min_y};
    offx_c   = {in_pos_x[DATA_W-1], in_pos_x} - {rect_min_x[DATA_W-1], rect_min_x};
    offy_c   = {in_pos_y[DATA_W-1], in_pos_y} - {rect_min_y[DATA_W-1], rect_min_y};
    w_ok_c   = !dx_c[DATA_W] && (dx_c != '0);
    h_ok_c   = !dy_c[DATA_W] && (dy_c != '0);
    inside_c = (in_pos_x >= rect_min_x) && (in_pos_x <= rect_max_x) &&
               (in_pos_y >= rect_min_y) && (in_pos_y <= rect_max_y);
    nx_c     = NXW'(root_count(root_tiles_x, ROOT_W'(MAX_ROOT_TILES))) << in_level;
    ny_c     = NXW'(root_count(root_tiles_y, ROOT_W'(MAX_ROOT_TILES))) << in_level;
    beyond_c = (CW'(in_tile_x_in) >= CW'(nx_c)) || (CW'(in_tile_y_in) >= CW'(ny_c));

    s1_ctrl_nxt.valid = start;
    s1_ctrl_nxt.op    = op_t'(in_operation);
    priority if (in_level > LEVEL_W'(MAX_LEVEL)) begin
      s1_ctrl_nxt.status = ST_LEVEL;
    end else if (!w_ok_c || !h_ok_c) begin
      s1_ctrl_nxt.status = ST_RANGE;
    end else if (in_operation == OP_LOCATE && !inside_c) begin
      s1_ctrl_nxt.status = ST_RANGE;
    end else if (in_operation == OP_EDGES && beyond_c) begin
      s1_ctrl_nxt.status = ST_TILE;
    end else begin
      s1_ctrl_nxt.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctrl_r <= '0;
    end else begin
      s1_ctrl_r <= s1_ctrl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_offx_r <= offx_c[DATA_W-1:0];
    s1_offy_r <= offy_c[DATA_W-1:0];
    s1_w_r    <= dx_c[DATA_W-1:0];
    s1_h_r    <= dy_c[DATA_W-1:0];
    s1_minx_r <= rect_min_x;
    s1_miny_r <= rect_min_y;
    s1_nx_r   <= nx_c;
    s1_ny_r   <= ny_c;
    s1_tx_r   <= NXW'(in_tile_x_in);
    s1_ty_r   <= NXW'(in_tile_y_in);
  end

  // Locate: offset * count over extent. Edges: coordinate * extent over count.
  always_comb begin
    a0_c  = (s1_ctrl_r.op == OP_LOCATE) ? s1_offx_r : s1_w_r;
    b0_c  = (s1_ctrl_r.op == OP_LOCATE) ? s1_nx_r : s1_tx_r;
    a1_c  = (s1_ctrl_r.op == OP_LOCATE) ? s1_offy_r : s1_h_r;
    b1_c  = (s1_ctrl_r.op == OP_LOCATE) ? s1_ny_r : s1_ty_r;
    tx1_c = NXW'(s1_tx_r + NXW'(1));
    ty1_c = NXW'(s1_ty_r + NXW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_o <= '0;
    end else begin
      ctrl_o <= s1_ctrl_r;
    end
  end

  always_ff @(posedge clk) begin
    min_x_o  <= s1_minx_r;
    min_y_o  <= s1_miny_r;
    nx_m1_o  <= NXW'(s1_nx_r - NXW'(1));
    ny_m1_o  <= NXW'(s1_ny_r - NXW'(1));
    dvd_o[0] <= PW'(a0_c) * PW'(b0_c);
    dvd_o[1] <= PW'(a1_c) * PW'(b1_c);
    dvd_o[2] <= PW'(s1_w_r) * PW'(tx1_c);
    dvd_o[3] <= PW'(s1_h_r) * PW'(ty1_c);
    dvs_o[0] <= (s1_ctrl_r.op == OP_LOCATE) ? s1_w_r : DATA_W'(s1_nx_r);
    dvs_o[1] <= (s1_ctrl_r.op == OP_LOCATE) ? s1_h_r : DATA_W'(s1_ny_r);
    dvs_o[2] <= DATA_W'(s1_nx_r);
    dvs_o[3] <= DATA_W'(s1_ny_r);
  end

endmodule

`default_nettype wire

// File: hdl/qtl_div.sv
// ----------------------------------------------------------------------------
// Quadtree tile locator divider lane
// Restoring divider, one quotient bit per register stage, one new division
// accepted every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module qtl_div #(
  parameter int PW = 57,
  parameter int DW = qtl_pkg::DATA_W,
  parameter int QW = qtl_pkg::QUO_W
) (
  input  wire           clk,
  input  wire  [PW-1:0] dvd_i,
  input  wire  [DW-1:0] dvs_i,
  output logic [QW-1:0] quo_o
);
  import qtl_pkg::*;

  logic [PW-1:0] rem_r [QW-1];
  logic [DW-1:0] dvs_r [QW-1];
  logic [QW-1:0] quo_r [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int SH = QW - 1 - s;
    logic [PW-1:0] rem_in;
    logic [DW-1:0] dvs_in;
    logic [QW-1:0] quo_in;
    logic          ge;
    logic [QW-1:0] quo_nxt;

    if (s == 0) begin : g_first
      assign rem_in = dvd_i;
      assign dvs_in = dvs_i;
      assign quo_in = '0;
    end else begin : g_rest
      assign rem_in = rem_r[s-1];
      assign dvs_in = dvs_r[s-1];
      assign quo_in = quo_r[s-1];
    end

    // The quotient is known to fit QW bits, so the remainder never overflows.
    always_comb begin
      ge      = (rem_in >> SH) >= PW'(dvs_in);
      quo_nxt = {quo_in[QW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      quo_r[s] <= quo_nxt;
    end

    if (s < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_r[s] <= ge ? PW'(rem_in - (PW'(dvs_in) << SH)) : rem_in;
        dvs_r[s] <= dvs_in;
      end
    end
  end

  assign quo_o = quo_r[QW-1];

endmodule

`default_nettype wire

// File: hdl/quadtree_tile_locator.sv
// Pipeline: two front stages, the 32-stage divider, then the output register
// that drives the result strobe.
// Throughput: one command per cycle; busy never rises and the result side
// cannot stall. Synchronous active-low reset clears the pipeline valid bits
// and loads the rectangle 0..1.0 by 0..1.0 with one root tile each way.
// ----------------------------------------------------------------------------
// Quadtree tile locator
// Maps a point to its quadtree tile, or a tile to its edges, over a
// configured rectangle, through four pipelined divider lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module quadtree_tile_locator #(
  parameter int MAX_LEVEL      = qtl_pkg::DEF_MAX_LEVEL,
  parameter int MAX_ROOT_TILES = qtl_pkg::DEF_MAX_ROOT_TILES
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                start,
  output logic                               busy,
  input  wire                                in_operation,
  input  wire  [qtl_pkg::LEVEL_W-1:0]        in_level,
  input  wire  signed [qtl_pkg::DATA_W-1:0]  in_pos_x,
  input  wire  signed [qtl_pkg::DATA_W-1:0]  in_pos_y,
  input  wire  [qtl_pkg::TILE_W-1:0]         in_tile_x_in,
  input  wire  [qtl_pkg::TILE_W-1:0]         in_tile_y_in,
  output logic                               out_valid,
  output logic [1:0]                         out_status,
  output logic [qtl_pkg::TILE_W-1:0]         out_tile_x,
  output logic [qtl_pkg::TILE_W-1:0]         out_tile_y,
  output logic signed [qtl_pkg::DATA_W-1:0]  out_edge_left,
  output logic signed [qtl_pkg::DATA_W-1:0]  out_edge_bottom,
  output logic signed [qtl_pkg::DATA_W-1:0]  out_edge_right,
  output logic signed [qtl_pkg::DATA_W-1:0]  out_edge_top,
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire  [qtl_pkg::PADDR_W-1:0]        paddr,
  input  wire  [qtl_pkg::DATA_W-1:0]         pwdata,
  output logic [qtl_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);
  import qtl_pkg::*;

  localparam int NXW = $clog2(MAX_ROOT_TILES + 1) + MAX_LEVEL;
  localparam int PW  = DATA_W + NXW;

  logic signed [DATA_W-1:0] min_x_r, min_y_r, max_x_r, max_y_r;
  logic [ROOT_W-1:0]        root_x_r, root_y_r;
  reg_idx_t                 idx_c;
  logic                     wr_c;

  qtl_ctrl_t         f_ctrl;
  logic [DATA_W-1:0] f_min_x, f_min_y;
  logic [NXW-1:0]    f_nx_m1, f_ny_m1;
  logic [PW-1:0]     f_dvd [4];
  logic [DATA_W-1:0] f_dvs [4];
  logic [QUO_W-1:0]  quo [4];

  qtl_ctrl_t         dl_ctrl_r [QUO_W];
  logic [DATA_W-1:0] dl_min_x_r [QUO_W];
  logic [DATA_W-1:0] dl_min_y_r [QUO_W];
  logic [NXW-1:0]    dl_nx_m1_r [QUO_W];
  logic [NXW-1:0]    dl_ny_m1_r [QUO_W];

  qtl_ctrl_t         t_ctrl;
  logic [QUO_W-1:0]  tx_clamp_c, ty_clamp_c;
  logic              ok_c;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign idx_c  = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr_c   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_x_r  <= '0;
      min_y_r  <= '0;
      max_x_r  <= DATA_W'(65536);
      max_y_r  <= DATA_W'(65536);
      root_x_r <= ROOT_W'(1);
      root_y_r <= ROOT_W'(1);
    end else if (wr_c) begin
      unique case (idx_c)
        REG_MIN_X:  min_x_r  <= pwdata;
        REG_MIN_Y:  min_y_r  <= pwdata;
        REG_MAX_X:  max_x_r  <= pwdata;
        REG_MAX_Y:  max_y_r  <= pwdata;
        REG_ROOT_X: root_x_r <= pwdata[ROOT_W-1:0];
        REG_ROOT_Y: root_y_r <= pwdata[ROOT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx_c)
      REG_MIN_X:  prdata = min_x_r;
      REG_MIN_Y:  prdata = min_y_r;
      REG_MAX_X:  prdata = max_x_r;
      REG_MAX_Y:  prdata = max_y_r;
      REG_ROOT_X: prdata = DATA_W'(root_x_r);
      REG_ROOT_Y: prdata = DATA_W'(root_y_r);
      default:    prdata = '0;
    endcase
  end

  qtl_front #(
    .MAX_LEVEL      (MAX_LEVEL),
    .MAX_ROOT_TILES (MAX_ROOT_TILES),
    .NXW            (NXW),
    .PW             (PW)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .in_level     (in_level),
    .in_pos_x     (in_pos_x),
    .in_pos_y     (in_pos_y),
    .in_tile_x_in (in_tile_x_in),
    .in_tile_y_in (in_tile_y_in),
    .rect_min_x   (min_x_r),
    .rect_min_y   (min_y_r),
    .rect_max_x   (max_x_r),
    .rect_max_y   (max_y_r),
    .root_tiles_x (root_x_r),
    .root_tiles_y (root_y_r),
    .ctrl_o       (f_ctrl),
    .min_x_o      (f_min_x),
    .min_y_o      (f_min_y),
    .nx_m1_o      (f_nx_m1),
    .ny_m1_o      (f_ny_m1),
    .dvd_o        (f_dvd),
    .dvs_o        (f_dvs)
  );

  // Lanes: tile x or left edge, tile y or bottom edge, right edge, top edge.
  for (genvar l = 0; l < 4; l++) begin : g_lane
    qtl_div #(
      .PW (PW),
      .DW (DATA_W),
      .QW (QUO_W)
    ) u_div (
      .clk   (clk),
      .dvd_i (f_dvd[l]),
      .dvs_i (f_dvs[l]),
      .quo_o (quo[l])
    );
  end

  // Sideband travels alongside the divider stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QUO_W; i++) begin
        dl_ctrl_r[i] <= '0;
      end
    end else begin
      dl_ctrl_r[0] <= f_ctrl;
      for (int i = 1; i < QUO_W; i++) begin
        dl_ctrl_r[i] <= dl_ctrl_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    dl_min_x_r[0] <= f_min_x;
    dl_min_y_r[0] <= f_min_y;
    dl_nx_m1_r[0] <= f_nx_m1;
    dl_ny_m1_r[0] <= f_ny_m1;
    for (int i = 1; i < QUO_W; i++) begin
      dl_min_x_r[i] <= dl_min_x_r[i-1];
      dl_min_y_r[i] <= dl_min_y_r[i-1];
      dl_nx_m1_r[i] <= dl_nx_m1_r[i-1];
      dl_ny_m1_r[i] <= dl_ny_m1_r[i-1];
    end
  end

  // A point on the far edge lands one past the grid and is pulled back.
  always_comb begin
    t_ctrl     = dl_ctrl_r[QUO_W-1];
    ok_c       = (t_ctrl.status == ST_OK);
    tx_clamp_c = (quo[0] > QUO_W'(dl_nx_m1_r[QUO_W-1])) ?
                 QUO_W'(dl_nx_m1_r[QUO_W-1]) : quo[0];
    ty_clamp_c = (quo[1] > QUO_W'(dl_ny_m1_r[QUO_W-1])) ?
                 QUO_W'(dl_ny_m1_r[QUO_W-1]) : quo[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= t_ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_status <= t_ctrl.status;
    if (ok_c && t_ctrl.op == OP_LOCATE) begin
      out_tile_x <= TILE_W'(tx_clamp_c);
      out_tile_y <= TILE_W'(ty_clamp_c);
    end else begin
      out_tile_x <= '0;
      out_tile_y <= '0;
    end
    if (ok_c && t_ctrl.op == OP_EDGES) begin
      out_edge_left   <= DATA_W'(dl_min_x_r[QUO_W-1] + quo[0]);
      out_edge_bottom <= DATA_W'(dl_min_y_r[QUO_W-1] + quo[1]);
      out_edge_right  <= DATA_W'(dl_min_x_r[QUO_W-1] + quo[2]);
      out_edge_top    <= DATA_W'(dl_min_y_r[QUO_W-1] + quo[3]);
    end else begin
      out_edge_left   <= '0;
      out_edge_bottom <= '0;
      out_edge_right  <= '0;
      out_edge_top    <= '0;
    end
  end

endmodule

`default_nettype wire

// File: hdl/qtl_checker.sv
// ----------------------------------------------------------------------------
// Quadtree tile locator port checker
// Watches the command and result ports of the locator over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "quadtree_tile_locator_assert.svh"

module qtl_checker (
  input wire                                clk,
  input wire                                rst_n,
  input wire                                start,
  input wire                                busy,
  input wire                                out_valid,
  input wire  [1:0]                         out_status,
  input wire  [qtl_pkg::TILE_W-1:0]         out_tile_x,
  input wire  [qtl_pkg::TILE_W-1:0]         out_tile_y,
  input wire  signed [qtl_pkg::DATA_W-1:0]  out_edge_left,
  input wire  signed [qtl_pkg::DATA_W-1:0]  out_edge_bottom,
  input wire  signed [qtl_pkg::DATA_W-1:0]  out_edge_right,
  input wire  signed [qtl_pkg::DATA_W-1:0]  out_edge_top
);
  import qtl_pkg::*;

  `QTL_ASSERT_NEVER(a_never_busy, busy, "locator raised busy")

  `QTL_ASSERT_IMP(a_result_has_command, out_valid, $past(start, LATENCY + 1), "result without a command at the fixed latency")

  `QTL_ASSERT_IMP(a_fail_fields_zero, out_valid && out_status != ST_OK, out_tile_x == '0 && out_tile_y == '0 && out_edge_left == '0 && out_edge_bottom == '0 && out_edge_right == '0 && out_edge_top == '0, "failed result carries nonzero fields")

  `QTL_ASSERT_IMP(a_edges_ordered, out_valid && out_status == ST_OK, out_edge_left <= out_edge_right && out_edge_bottom <= out_edge_top, "tile edges out of order")

endmodule

bind quadtree_tile_locator qtl_checker u_qtl_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_tile_x      (out_tile_x),
  .out_tile_y      (out_tile_y),
  .out_edge_left   (out_edge_left),
  .out_edge_bottom (out_edge_bottom),
  .out_edge_right  (out_edge_right),
  .out_edge_top    (out_edge_top)
);

`default_nettype wire
